[rtl/core/spf_pkg.sv]
// Shared constants for the scanline polygon fill.
// No dependencies.
package spf_pkg;
  localparam int MaxVertices = 16;
  localparam int VertAw      = 4;   // vertex / crossing store address bits
  localparam int CntW        = 5;   // counts up to MaxVertices
  localparam int CoordW      = 16;
  localparam int StepW       = 15;
  localparam int NumW        = 34;  // product magnitude for the divider
  localparam int DenW        = 17;

  localparam logic ActAppend = 1'b0;
  localparam logic ActPull   = 1'b1;

  localparam logic RegGridStep = 1'b0;
  localparam logic RegHeight   = 1'b1;
endpackage

[rtl/core/scanline_polygon_fill.sv]
// Even-odd scanline polygon fill, extruded along z, Q8.8 fixed point.
// Depends on spf_pkg and spf_div.
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------------------------------
// command   | start & !busy              | action, vertex_x, vertex_y
// result    | result_strobe (one cycle)  | point_x/y/z, point_valid, last_point,
//           |                            | vertex_overflow
// config    | psel&penable&pwrite&pready | paddr, pwdata (grid_step, extrude_height)
//
// An append is taken in S_IDLE. A pull inside a span steps z, else x, in S_ADV.
// Moving to the next pair reads both its crossings (S_LOAD_A to S_LOAD_C).
// Each scanline visits every edge; a crossing takes a multiply, the bit-serial divider,
// and an insertion into the crossing store through its single read port, which moves
// larger stored crossings up one place. A first pull adds a min/max pass over vertex y.
// Reset is synchronous; no clearing pass, stores are tracked by counts.
// The receiver cannot stall: each result is shown for one cycle with result_strobe.
module scanline_polygon_fill (
  input  logic                clk,
  input  logic                rst,
  // command transaction
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic signed [15:0]  vertex_x,
  input  logic signed [15:0]  vertex_y,
  // result transaction
  output logic                result_strobe,
  output logic signed [15:0]  point_x,
  output logic signed [15:0]  point_y,
  output logic [14:0]         point_z,
  output logic                point_valid,
  output logic                last_point,
  output logic                vertex_overflow,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  typedef enum logic [4:0] {
    S_IDLE, S_MM, S_SEEK, S_ED_RD1, S_ED_RD2, S_ED_CHK, S_MUL, S_DIV_GO, S_DIV_WAIT,
    S_INS_RD, S_INS_CMP, S_ED_NEXT, S_SEEK_END, S_LOAD_A, S_LOAD_B, S_LOAD_C, S_ADV
  } state_t;

  state_t state;

  // configuration registers
  logic [14:0] grid_step;
  logic [14:0] extrude_height;
  logic [14:0] st;
  assign st = (grid_step == '0) ? 15'd1 : grid_step;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      spf_pkg::RegGridStep: prdata = {17'd0, grid_step};
      spf_pkg::RegHeight:   prdata = {17'd0, extrude_height};
      default:              prdata = '0;
    endcase
  end

  // vertex store: synchronous memories, one read port each
  logic signed [15:0] vx_mem [spf_pkg::MaxVertices];
  logic signed [15:0] vy_mem [spf_pkg::MaxVertices];
  logic [spf_pkg::VertAw-1:0] v_raddr;
  logic signed [15:0] vx_rd, vy_rd;

  // crossing store
  logic signed [15:0] cs_mem [spf_pkg::MaxVertices];
  logic [spf_pkg::VertAw-1:0] cs_raddr, cs_waddr;
  logic               cs_we;
  logic signed [15:0] cs_wdata, cs_rd;

  // polygon and cursor state
  logic [spf_pkg::CntW-1:0] vcount, ccount, pair, eidx, mmi, kidx;
  logic               dropped, active, first;
  logic signed [17:0] scan_y, scan_x, seek_y;
  logic [16:0]        scan_z;
  logic signed [15:0] top_y, lo_y, hi_x, x1, y1, x2, y2, cx;
  logic signed [34:0] prod;
  logic signed [16:0] den_s;

  // divider
  logic               div_start;
  logic               div_done;
  logic [spf_pkg::NumW-1:0] quo;
  logic [spf_pkg::NumW-1:0] num_mag;
  logic [spf_pkg::DenW-1:0] den_mag;
  logic [34:0]        prod_abs;
  logic [16:0]        den_abs;

  assign prod_abs = prod[34] ? 35'(-prod) : 35'(prod);
  assign den_abs  = den_s[16] ? 17'(-den_s) : 17'(den_s);
  assign num_mag  = prod_abs[spf_pkg::NumW-1:0];
  assign den_mag  = den_abs;
  assign div_start = (state == S_DIV_GO);

  spf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_mag),
    .den   (den_mag),
    .done  (div_done),
    .quo   (quo)
  );

  // signed quotient, truncated toward zero, then the crossing x
  logic signed [17:0] q_s;
  logic signed [17:0] cx_full;
  assign q_s     = (prod[34] ^ den_s[16]) ? -$signed({1'b0, quo[16:0]})
                                          :  $signed({1'b0, quo[16:0]});
  assign cx_full = 18'(x1) + q_s;

  // next edge end index wraps to vertex 0
  logic [spf_pkg::CntW-1:0] eidx_nx;
  assign eidx_nx = (eidx + 5'd1 == vcount) ? '0 : eidx + 5'd1;

  // straddle test on the current scanline
  logic straddle;
  assign straddle = ((18'(y1) < seek_y) && (18'(y2) >= seek_y)) ||
                    ((18'(y2) < seek_y) && (18'(y1) >= seek_y));

  // cursor advance arithmetic
  logic [16:0]        z_nx;
  logic signed [17:0] x_nx;
  logic [spf_pkg::CntW-1:0] pair_nx;
  assign z_nx    = scan_z + 17'(st);
  assign x_nx    = scan_x + 18'($signed({1'b0, st}));
  assign pair_nx = pair + 5'd2;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // memory read address selection
  always_comb begin
    v_raddr  = eidx[spf_pkg::VertAw-1:0];
    cs_raddr = pair[spf_pkg::VertAw-1:0];
    unique case (state)
      S_MM:     v_raddr  = mmi[spf_pkg::VertAw-1:0];
      S_ED_RD2: v_raddr  = eidx_nx[spf_pkg::VertAw-1:0];
      S_INS_RD: cs_raddr = 4'(kidx - 5'd1);
      S_LOAD_B: cs_raddr = 4'(pair + 5'd1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    vx_rd <= vx_mem[v_raddr];
    vy_rd <= vy_mem[v_raddr];
    if (accept && action == spf_pkg::ActAppend && !active &&
        vcount < 5'(spf_pkg::MaxVertices)) begin
      vx_mem[vcount[spf_pkg::VertAw-1:0]] <= vertex_x;
      vy_mem[vcount[spf_pkg::VertAw-1:0]] <= vertex_y;
    end
  end

  always_ff @(posedge clk) begin
    cs_rd <= cs_mem[cs_raddr];
    if (cs_we) cs_mem[cs_waddr] <= cs_wdata;
  end

  always_comb begin
    cs_we    = 1'b0;
    cs_waddr = kidx[spf_pkg::VertAw-1:0];
    cs_wdata = cx;
    if (state == S_INS_RD && kidx == '0) begin
      cs_we = 1'b1;
    end else if (state == S_INS_CMP) begin
      cs_we = 1'b1;
      if (cs_rd > cx) cs_wdata = cs_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      grid_step      <= 15'd3;
      extrude_height <= 15'd128;
      vcount         <= '0;
      dropped        <= 1'b0;
      active         <= 1'b0;
      ccount         <= '0;
      result_strobe  <= 1'b0;
      first          <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          spf_pkg::RegGridStep: grid_step      <= pwdata[14:0];
          spf_pkg::RegHeight:   extrude_height <= pwdata[14:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == spf_pkg::ActAppend) begin
              if (!active) begin
                if (vcount < 5'(spf_pkg::MaxVertices)) vcount <= vcount + 5'd1;
                else dropped <= 1'b1;
              end
            end else if (active) begin
              point_x         <= scan_x[15:0];
              point_y         <= scan_y[15:0];
              point_z         <= scan_z[14:0];
              point_valid     <= 1'b1;
              vertex_overflow <= dropped;
              state           <= S_ADV;
            end else if (vcount < 5'd3) begin
              point_x         <= '0;
              point_y         <= '0;
              point_z         <= '0;
              point_valid     <= 1'b0;
              last_point      <= 1'b1;
              vertex_overflow <= dropped;
              result_strobe   <= 1'b1;
              vcount          <= '0;
              dropped         <= 1'b0;
            end else begin
              mmi   <= '0;
              first <= 1'b1;
              state <= S_MM;
            end
          end
        end

        S_MM: begin
          // data of entry mmi-1 arrives while entry mmi is read
          if (mmi == 5'd1) begin
            lo_y  <= vy_rd;
            top_y <= vy_rd;
          end else if (mmi != '0) begin
            if (vy_rd < lo_y)  lo_y  <= vy_rd;
            if (vy_rd > top_y) top_y <= vy_rd;
          end
          mmi <= mmi + 5'd1;
          if (mmi == vcount) begin
            seek_y <= 18'((mmi == 5'd1 || vy_rd < lo_y) ? vy_rd : lo_y);
            state  <= S_SEEK;
          end
        end

        S_SEEK: begin
          if (seek_y <= 18'(top_y)) begin
            ccount <= '0;
            eidx   <= '0;
            state  <= S_ED_RD1;
          end else begin
            // no scanline with a pair left: polygon done
            if (first) begin
              point_x     <= '0;
              point_y     <= '0;
              point_z     <= '0;
              point_valid <= 1'b0;
            end
            last_point      <= 1'b1;
            vertex_overflow <= dropped;
            result_strobe   <= 1'b1;
            vcount          <= '0;
            dropped         <= 1'b0;
            active          <= 1'b0;
            ccount          <= '0;
            state           <= S_IDLE;
          end
        end

        S_ED_RD1: state <= S_ED_RD2;

        S_ED_RD2: begin
          x1    <= vx_rd;
          y1    <= vy_rd;
          state <= S_ED_CHK;
        end

        S_ED_CHK: begin
          x2    <= vx_rd;
          y2    <= vy_rd;
          state <= S_MUL;
        end

        S_MUL: begin
          if (straddle) begin
            prod  <= 35'((seek_y - 18'(y1)) * 18'(17'(x2) - 17'(x1)));
            den_s <= 17'(y2) - 17'(y1);
            state <= S_DIV_GO;
          end else begin
            state <= S_ED_NEXT;
          end
        end

        S_DIV_GO: state <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (div_done) begin
            cx    <= cx_full[15:0];
            kidx  <= ccount;
            state <= S_INS_RD;
          end
        end

        S_INS_RD: begin
          if (kidx == '0) begin
            ccount <= ccount + 5'd1;
            state  <= S_ED_NEXT;
          end else begin
            state <= S_INS_CMP;
          end
        end

        S_INS_CMP: begin
          if (cs_rd > cx) begin
            kidx  <= kidx - 5'd1;
            state <= S_INS_RD;
          end else begin
            ccount <= ccount + 5'd1;
            state  <= S_ED_NEXT;
          end
        end

        S_ED_NEXT: begin
          eidx  <= eidx + 5'd1;
          state <= (eidx + 5'd1 == vcount) ? S_SEEK_END : S_ED_RD1;
        end

        S_SEEK_END: begin
          if (ccount >= 5'd2) begin
            pair   <= '0;
            scan_y <= seek_y;
            scan_z <= '0;
            state  <= S_LOAD_A;
          end else begin
            seek_y <= seek_y + 18'($signed({1'b0, st}));
            state  <= S_SEEK;
          end
        end

        S_LOAD_A: state <= S_LOAD_B;

        S_LOAD_B: begin
          scan_x <= 18'(cs_rd);
          state  <= S_LOAD_C;
        end

        S_LOAD_C: begin
          hi_x <= cs_rd;
          if (first) begin
            // first point of the polygon goes out, then the cursor moves on
            first           <= 1'b0;
            active          <= 1'b1;
            point_x         <= scan_x[15:0];
            point_y         <= scan_y[15:0];
            point_z         <= scan_z[14:0];
            point_valid     <= 1'b1;
            vertex_overflow <= dropped;
            state           <= S_ADV;
          end else begin
            last_point    <= 1'b0;
            result_strobe <= 1'b1;
            state         <= S_IDLE;
          end
        end

        S_ADV: begin
          if (z_nx <= 17'(extrude_height)) begin
            scan_z        <= z_nx;
            last_point    <= 1'b0;
            result_strobe <= 1'b1;
            state         <= S_IDLE;
          end else begin
            scan_z <= '0;
            if (x_nx <= 18'(hi_x)) begin
              scan_x        <= x_nx;
              last_point    <= 1'b0;
              result_strobe <= 1'b1;
              state         <= S_IDLE;
            end else if (pair_nx + 5'd1 < ccount) begin
              pair  <= pair_nx;
              state <= S_LOAD_A;
            end else begin
              seek_y <= scan_y + 18'($signed({1'b0, st}));
              state  <= S_SEEK;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/spf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spf_pkg.
module spf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [spf_pkg::NumW-1:0]     num,
  input  logic [spf_pkg::DenW-1:0]     den,
  output logic                         done,
  output logic [spf_pkg::NumW-1:0]     quo
);
  logic [spf_pkg::NumW-1:0] nsh;
  logic [spf_pkg::DenW-1:0] rem;
  logic [spf_pkg::DenW-1:0] dv;
  logic [5:0]               cnt;
  logic                     run;
  logic [spf_pkg::DenW-1:0] shifted;

  assign shifted = {rem[spf_pkg::DenW-2:0], nsh[spf_pkg::NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'(spf_pkg::NumW);
        nsh <= num;
        dv  <= den;
        rem <= '0;
        quo <= '0;
      end else if (run) begin
        nsh <= {nsh[spf_pkg::NumW-2:0], 1'b0};
        if (shifted >= dv) begin
          rem <= shifted - dv;
          quo <= {quo[spf_pkg::NumW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[spf_pkg::NumW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/spf_checker.sv]
// Port-level checks for the scanline polygon fill.
// Depends on scanline_polygon_fill (bound below).
module spf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic action,
  input logic result_strobe,
  input logic point_valid,
  input logic last_point
);
  // results only appear once the block has gone idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !busy) else $error("result while busy");

  // an empty result always closes the polygon
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !point_valid) |-> last_point) else $error("empty result not last");

  // appends never yield a result
  a_append_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !action) |=> !result_strobe) else $error("result after append");

  // reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_strobe)) else $error("not idle after reset");
endmodule

bind scanline_polygon_fill spf_checker u_spf_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .action        (action),
  .result_strobe (result_strobe),
  .point_valid   (point_valid),
  .last_point    (last_point)
);
